### sv/bbct_pkg.sv
// bbct_pkg: shared types and codes for the block buffer cache tag manager.
// Holds action, command, result and status definitions used by the top, front and back modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbct_pkg;

	localparam int unsigned ACT_W  = 2;
	localparam int unsigned DEV_W  = 8;
	localparam int unsigned BLK_W  = 32;
	localparam int unsigned SLOT_W = 5;
	localparam int unsigned REF_W  = 8;
	localparam int unsigned STAT_W = 2;

	localparam logic [REF_W-1:0] REF_MAX = '1;

	localparam logic [ACT_W-1:0] ACT_READ    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PIN     = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOSLOT = 2'd1;
	localparam logic [STAT_W-1:0] ST_COUNT  = 2'd2;

	typedef enum logic [2:0] {
		OP_READ,
		OP_RELEASE,
		OP_PIN,
		OP_NOSLOT,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [DEV_W-1:0]   device;
		logic [BLK_W-1:0]   block_number;
		logic [SLOT_W-1:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot_out;
		logic               hit;
		logic               needs_disk_read;
		logic [REF_W-1:0]   ref_count;
		logic [STAT_W-1:0]  status;
	} res_t;

endpackage

`default_nettype wire

### sv/block_buffer_cache_tags.sv
// block_buffer_cache_tags: tag and reference-count manager for disk buffer slots.
// Request side: push/full; an action, device, block number and slot transfer
// when push is high and full is low. Result side: empty/pop; the oldest result
// is on slot_out, hit, needs_disk_read, ref_count and status while empty is low
// and transfers when pop is high. Every request yields exactly one result.
// A front stage registers and classifies each request into a two-entry command
// queue; the back sequencer runs one command at a time (take, compare all
// slot tags in parallel, pick the matching or lowest free slot for a read or the
// given slot otherwise, update counts) and writes the result into a two-entry
// result queue. It takes a new command only after the last result is written.
// When the result side stalls, the back holds its finished result until the
// result queue has room; the command queue and front stage keep taking
// requests until they fill, then full rises.
// Reset clears all used bits, valid bits and counts at once, with no clearing pass; tag values are not reset.
// Depends on bbct_pkg, bbct_front, bbct_fifo and bbct_back.
`timescale 1ns / 1ps
`default_nettype none

module block_buffer_cache_tags #(
	parameter int unsigned NUM_SLOTS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [bbct_pkg::ACT_W-1:0]   action,
	input  wire logic [bbct_pkg::DEV_W-1:0]   device,
	input  wire logic [bbct_pkg::BLK_W-1:0]   block_number,
	input  wire logic [bbct_pkg::SLOT_W-1:0]  slot,
	output logic                              empty,
	input  wire logic                         pop,
	output logic [bbct_pkg::SLOT_W-1:0]       slot_out,
	output logic                              hit,
	output logic                              needs_disk_read,
	output logic [bbct_pkg::REF_W-1:0]        ref_count,
	output logic [bbct_pkg::STAT_W-1:0]       status
);

	localparam int unsigned CMD_W = $bits(bbct_pkg::cmd_t);
	localparam int unsigned RES_W = $bits(bbct_pkg::res_t);

	logic           cmd_push;
	logic           cmd_full;
	logic           cmd_empty;
	logic           cmd_pop;
	bbct_pkg::cmd_t cmd_front;
	bbct_pkg::cmd_t cmd_back;
	logic           res_push;
	logic           res_full;
	bbct_pkg::res_t res_back;
	bbct_pkg::res_t res_head;

	bbct_front #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.device       (device),
		.block_number (block_number),
		.slot         (slot),
		.cmd_push     (cmd_push),
		.cmd          (cmd_front),
		.cmd_full     (cmd_full)
	);

	bbct_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_front),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_back),
		.empty  (cmd_empty)
	);

	bbct_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd_back),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_back),
		.res_full  (res_full)
	);

	bbct_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_back),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign slot_out        = res_head.slot_out;
	assign hit             = res_head.hit;
	assign needs_disk_read = res_head.needs_disk_read;
	assign ref_count       = res_head.ref_count;
	assign status          = res_head.status;

endmodule

`default_nettype wire

### sv/bbct_fifo.sv
// bbct_fifo: small synchronous queue with push/full and pop/empty sides.
// Generic width and depth (pointers wrap at DEPTH-1); no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bbct_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

### sv/bbct_front.sv
// bbct_front: accepts request transfers, classifies them into commands.
// Depends on bbct_pkg; feeds the command queue.
`timescale 1ns / 1ps
`default_nettype none

module bbct_front #(
	parameter int unsigned NUM_SLOTS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [bbct_pkg::ACT_W-1:0]  action,
	input  wire logic [bbct_pkg::DEV_W-1:0]  device,
	input  wire logic [bbct_pkg::BLK_W-1:0]  block_number,
	input  wire logic [bbct_pkg::SLOT_W-1:0] slot,
	output logic                             cmd_push,
	output bbct_pkg::cmd_t                   cmd,
	input  wire logic                        cmd_full
);

	logic           valid_s1;
	bbct_pkg::cmd_t cmd_s1;
	bbct_pkg::cmd_t cmd_next;
	logic           accept;
	logic           slot_bad;

	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;
	assign cmd      = cmd_s1;
	assign slot_bad = (32'(slot) >= 32'(NUM_SLOTS));

	always_comb begin
		cmd_next.device       = device;
		cmd_next.block_number = block_number;
		cmd_next.slot         = slot;
		unique case (action)
			bbct_pkg::ACT_READ: begin
				cmd_next.op = bbct_pkg::OP_READ;
			end
			bbct_pkg::ACT_RELEASE: begin
				cmd_next.op = slot_bad ? bbct_pkg::OP_NOSLOT : bbct_pkg::OP_RELEASE;
			end
			bbct_pkg::ACT_PIN: begin
				cmd_next.op = slot_bad ? bbct_pkg::OP_NOSLOT : bbct_pkg::OP_PIN;
			end
			default: begin
				cmd_next.op = bbct_pkg::OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && cmd_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_next;
		end
	end

endmodule

`default_nettype wire

### sv/bbct_back.sv
// bbct_back: slot tag store, reference counts and the four-step sequencer
// that executes one command at a time. Depends on bbct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbct_back #(
	parameter int unsigned NUM_SLOTS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bbct_pkg::cmd_t cmd_in,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	output logic                res_push,
	output bbct_pkg::res_t      res,
	input  wire logic           res_full
);

	localparam int unsigned IDX_W = $clog2(NUM_SLOTS);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_MATCH  = 4'b0010,
		S_PICK   = 4'b0100,
		S_UPDATE = 4'b1000
	} bstate_t;

	bstate_t                          state_q;
	bbct_pkg::cmd_t                   cmd_q;

	logic [NUM_SLOTS-1:0]             used_q;
	logic [NUM_SLOTS-1:0]             dv_q;
	logic [bbct_pkg::DEV_W-1:0]       dev_q [NUM_SLOTS];
	logic [bbct_pkg::BLK_W-1:0]       blk_q [NUM_SLOTS];
	logic [bbct_pkg::REF_W-1:0]       refs_q [NUM_SLOTS];

	logic [NUM_SLOTS-1:0]             hit_vec;
	logic [NUM_SLOTS-1:0]             free_vec;
	logic [NUM_SLOTS-1:0]             hit_vec_q;
	logic [NUM_SLOTS-1:0]             free_vec_q;

	logic                             hit_any;
	logic                             free_any;
	logic [IDX_W-1:0]                 hit_idx;
	logic [IDX_W-1:0]                 free_idx;

	logic                             hit_q;
	logic                             found_q;
	logic [IDX_W-1:0]                 sel_idx_q;

	logic [bbct_pkg::REF_W-1:0]       cur_refs;
	logic                             cur_dv;
	logic [bbct_pkg::REF_W-1:0]       new_refs;
	logic                             wr_refs;
	logic                             wr_tag;
	logic                             set_dv;
	logic                             do_update;
	logic [bbct_pkg::SLOT_W-1:0]      sel_slot;

	assign cmd_pop   = (state_q == S_IDLE) && !cmd_empty;
	assign do_update = (state_q == S_UPDATE) && !res_full;
	assign res_push  = do_update;
	assign cur_refs  = refs_q[sel_idx_q];
	assign cur_dv    = dv_q[sel_idx_q];
	assign sel_slot  = bbct_pkg::SLOT_W'(32'(sel_idx_q));

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hit_vec[i]  = used_q[i] && (dev_q[i] == cmd_q.device)
				&& (blk_q[i] == cmd_q.block_number);
			free_vec[i] = (refs_q[i] == '0);
		end
	end

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (hit_vec_q[i]) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (free_vec_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		res          = '0;
		new_refs     = cur_refs;
		wr_refs      = 1'b0;
		wr_tag       = 1'b0;
		set_dv       = 1'b0;
		res.slot_out = cmd_q.slot;
		unique case (cmd_q.op)
			bbct_pkg::OP_READ: begin
				res.slot_out = '0;
				if (hit_q) begin
					res.slot_out        = sel_slot;
					res.hit             = 1'b1;
					res.needs_disk_read = !cur_dv;
					set_dv              = 1'b1;
					if (cur_refs == bbct_pkg::REF_MAX) begin
						res.status = bbct_pkg::ST_COUNT;
					end else begin
						new_refs = cur_refs + 1'b1;
						wr_refs  = 1'b1;
					end
					res.ref_count = new_refs;
				end else if (found_q) begin
					res.slot_out        = sel_slot;
					res.needs_disk_read = 1'b1;
					new_refs            = bbct_pkg::REF_W'(1);
					wr_refs             = 1'b1;
					wr_tag              = 1'b1;
					set_dv              = 1'b1;
					res.ref_count       = new_refs;
				end else begin
					res.status = bbct_pkg::ST_NOSLOT;
				end
			end
			bbct_pkg::OP_RELEASE: begin
				if (cur_refs == '0) begin
					res.status = bbct_pkg::ST_COUNT;
				end else begin
					new_refs = cur_refs - 1'b1;
					wr_refs  = 1'b1;
				end
				res.ref_count = new_refs;
			end
			bbct_pkg::OP_PIN: begin
				if (cur_refs == bbct_pkg::REF_MAX) begin
					res.status = bbct_pkg::ST_COUNT;
				end else begin
					new_refs = cur_refs + 1'b1;
					wr_refs  = 1'b1;
				end
				res.ref_count = new_refs;
			end
			bbct_pkg::OP_NOSLOT: begin
				res.status = bbct_pkg::ST_NOSLOT;
			end
			default: begin
				res.status = bbct_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_in;
		end
		if (state_q == S_MATCH) begin
			hit_vec_q  <= hit_vec;
			free_vec_q <= free_vec;
		end
		if (state_q == S_PICK) begin
			hit_q   <= hit_any;
			found_q <= free_any;
			if (cmd_q.op == bbct_pkg::OP_READ) begin
				sel_idx_q <= hit_any ? hit_idx : free_idx;
			end else begin
				sel_idx_q <= IDX_W'(cmd_q.slot);
			end
		end
		if (do_update && wr_tag) begin
			dev_q[sel_idx_q] <= cmd_q.device;
			blk_q[sel_idx_q] <= cmd_q.block_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			dv_q   <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				refs_q[i] <= '0;
			end
		end else if (do_update) begin
			if (wr_tag) begin
				used_q[sel_idx_q] <= 1'b1;
			end
			if (set_dv) begin
				dv_q[sel_idx_q] <= 1'b1;
			end
			if (wr_refs) begin
				refs_q[sel_idx_q] <= new_refs;
			end
		end
	end

	a_tag_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK) |-> $onehot0(hit_vec_q))
		else $error("tag present in more than one slot");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_update && wr_tag) |=> (refs_q[$past(sel_idx_q)] == bbct_pkg::REF_W'(1)))
		else $error("allocated slot count is not one");

	a_read_ok_refs: assert property (@(posedge clk) disable iff (!arst_n)
		(do_update && (cmd_q.op == bbct_pkg::OP_READ) && (res.status != bbct_pkg::ST_NOSLOT))
		|-> (res.ref_count != '0))
		else $error("granted read with zero count");

	a_pop_to_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q == S_MATCH))
		else $error("command popped without starting match");

endmodule

`default_nettype wire
